FILE: rtl/core/ipid_pkg.sv
// Shared types and constants for the velocity-form PID with setpoint preview.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ipid_pkg;

  localparam int VALUE_BITS    = 24;              // signed Q8.16 values
  localparam int ERR_BITS      = VALUE_BITS + 1;  // difference of two values
  localparam int COEF_BITS     = 24;
  localparam int FRAC_BITS     = 16;
  localparam int ROUND_HALF    = 2 ** (FRAC_BITS - 1);
  localparam int DRIVE_BITS    = 19;              // unsigned Q3.16
  localparam int DRIVE_MAX     = 327680;          // 5.0
  localparam int SMOOTH_BITS   = 17;
  localparam int ONE_Q16       = 65536;
  localparam int PREVIEW_BITS  = 3;
  localparam int WIN_S_BITS    = 23;
  localparam int WIN_MS_BITS   = 33;
  localparam int MS_PER_S      = 1000;
  localparam int TIME_BITS     = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_SETPOINT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_NOW       = 3'd0,
    CFG_COEF_PREV      = 3'd1,
    CFG_COEF_PREV2     = 3'd2,
    CFG_SMOOTHING      = 3'd3,
    CFG_PREVIEW        = 3'd4,
    CFG_START_SETPOINT = 3'd5,
    CFG_WINDOW_START   = 3'd6,
    CFG_WINDOW_END     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] q0;
    logic signed [COEF_BITS-1:0] q1;
    logic signed [COEF_BITS-1:0] q2;
  } coef_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipid_if.sv
// Valid/ready channel interfaces for sample/setpoint items and results.
// Depends on ipid_pkg for field widths and the operation code.
`default_nettype none

interface ipid_in_if;
  import ipid_pkg::*;

  logic                         valid;
  logic                         ready;
  op_t                          operation;
  logic signed [VALUE_BITS-1:0] measured;
  logic signed [VALUE_BITS-1:0] target_offer;
  logic [TIME_BITS-1:0]         time_ms;

  modport source (output valid, output operation, output measured,
                  output target_offer, output time_ms, input ready);
  modport sink   (input valid, input operation, input measured,
                  input target_offer, input time_ms, output ready);
endinterface

interface ipid_out_if;
  import ipid_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [DRIVE_BITS-1:0]        drive;
  logic                         setpoint_taken;
  logic signed [VALUE_BITS-1:0] newest_setpoint;

  modport source (output valid, output drive, output setpoint_taken,
                  output newest_setpoint, input ready);
  modport sink   (input valid, input drive, input setpoint_taken,
                  input newest_setpoint, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ipid_pid_calc.sv
// PID increment: error, three weighted products, round to Q.16, clamp drive.
// Depends on ipid_pkg.
`default_nettype none

module ipid_pid_calc (
  input  ipid_pkg::coef_t                       coef_i,
  input  logic signed [ipid_pkg::VALUE_BITS-1:0] target_i,
  input  logic signed [ipid_pkg::VALUE_BITS-1:0] meas_i,
  input  logic signed [ipid_pkg::ERR_BITS-1:0]   err1_i,
  input  logic signed [ipid_pkg::ERR_BITS-1:0]   err2_i,
  input  logic [ipid_pkg::DRIVE_BITS-1:0]        drive_i,
  output logic signed [ipid_pkg::ERR_BITS-1:0]   err0_o,
  output logic [ipid_pkg::DRIVE_BITS-1:0]        drive_o
);
  import ipid_pkg::*;

  localparam int PROD_W = COEF_BITS + ERR_BITS;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF_LSB  = SUM_W'(ROUND_HALF);
  localparam logic signed [SUM_W-1:0] DRIVE_TOP = SUM_W'(DRIVE_MAX);

  logic signed [COEF_BITS-1:0] q0, q1, q2;
  logic signed [PROD_W-1:0]    prod0, prod1, prod2;
  logic signed [SUM_W-1:0]     sum, rnd, dsum;

  assign q0 = coef_i.q0;
  assign q1 = coef_i.q1;
  assign q2 = coef_i.q2;

  assign err0_o = target_i - meas_i;

  assign prod0 = q0 * err0_o;
  assign prod1 = q1 * err1_i;
  assign prod2 = q2 * err2_i;
  assign sum   = prod0 + prod1 + prod2;

  // round half up: floor((sum + 0.5 lsb) / 2^16)
  assign rnd  = (sum + HALF_LSB) >>> FRAC_BITS;
  assign dsum = $signed({{(SUM_W - DRIVE_BITS){1'b0}}, drive_i}) + rnd;

  always_comb begin
    if (dsum[SUM_W-1]) begin
      drive_o = '0;
    end else if (dsum > DRIVE_TOP) begin
      drive_o = DRIVE_BITS'(DRIVE_MAX);
    end else begin
      drive_o = dsum[DRIVE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipid_sp_filter.sv
// First-order setpoint prefilter: alfa*last + (1-alfa)*offer, rounded to Q.16.
// Depends on ipid_pkg.
`default_nettype none

module ipid_sp_filter (
  input  logic [ipid_pkg::SMOOTH_BITS-1:0]       smoothing_i,
  input  logic signed [ipid_pkg::VALUE_BITS-1:0] last_i,
  input  logic signed [ipid_pkg::VALUE_BITS-1:0] offer_i,
  output logic signed [ipid_pkg::VALUE_BITS-1:0] filtered_o
);
  import ipid_pkg::*;

  localparam int FPROD_W = SMOOTH_BITS + 1 + VALUE_BITS;
  localparam int FSUM_W  = FPROD_W + 1;
  localparam logic signed [FSUM_W-1:0] HALF_LSB = FSUM_W'(ROUND_HALF);

  logic [SMOOTH_BITS-1:0]     alfa, beta;
  logic signed [SMOOTH_BITS:0] alfa_s, beta_s;
  logic signed [FPROD_W-1:0]  prod_a, prod_b;
  logic signed [FSUM_W-1:0]   sum, rnd;

  assign alfa   = (smoothing_i > SMOOTH_BITS'(ONE_Q16)) ? SMOOTH_BITS'(ONE_Q16) : smoothing_i;
  assign beta   = SMOOTH_BITS'(ONE_Q16) - alfa;
  assign alfa_s = $signed({1'b0, alfa});
  assign beta_s = $signed({1'b0, beta});

  assign prod_a = alfa_s * last_i;
  assign prod_b = beta_s * offer_i;
  assign sum    = prod_a + prod_b;
  assign rnd    = (sum + HALF_LSB) >>> FRAC_BITS;

  // wraps to the value width, same as the stored line slots
  assign filtered_o = rnd[VALUE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/incremental_pid_with_setpoint_preview.sv
// Velocity-form discrete PID in signed Q8.16 with a setpoint preview line.
// One item is accepted every clock cycle while the result is not held back; an item
// passes through the input register, then the result register. The loop through the
// drive, error history and line state closes combinationally: three 24x25
// multiplies, an adder, the rounding shift and the 0..5.0 clamp for a sample,
// or two 18x24 multiplies for the prefilter of a setpoint offer. A full result
// register stalls the input register only when the result is not taken.
// Depends on ipid_pkg, ipid_if, ipid_pid_calc and ipid_sp_filter.
`default_nettype none

module incremental_pid_with_setpoint_preview #(
  parameter int LINE_DEPTH = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ipid_in_if.sink                             in_if,
  ipid_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [ipid_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [ipid_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ipid_pkg::*;

  localparam int LIDX_W = $clog2(LINE_DEPTH);
  localparam logic [LIDX_W-1:0] LAST_SLOT = LIDX_W'(LINE_DEPTH - 1);

  // configuration
  coef_t                   coef_r;
  logic [SMOOTH_BITS-1:0]  smoothing_r;
  logic [PREVIEW_BITS-1:0] preview_r;
  logic [WIN_MS_BITS-1:0]  win_lo_r, win_hi_r;
  logic [WIN_MS_BITS-1:0]  cfg_ms;
  cfg_idx_t                cfg_sel;

  // input register
  logic                         in_vld_r;
  op_t                          in_op_r;
  logic signed [VALUE_BITS-1:0] in_meas_r;
  logic signed [VALUE_BITS-1:0] in_offer_r;
  logic [TIME_BITS-1:0]         in_time_r;

  // controller state
  logic [DRIVE_BITS-1:0]        drive_r, drive_nxt, drive_calc;
  logic signed [ERR_BITS-1:0]   err0_r, err1_r, err0_calc;
  logic signed [VALUE_BITS-1:0] line_r   [LINE_DEPTH];
  logic signed [VALUE_BITS-1:0] line_nxt [LINE_DEPTH];
  logic signed [VALUE_BITS-1:0] filt_r, filt_calc;

  // result register
  logic                         out_valid_r;
  logic [DRIVE_BITS-1:0]        out_drive_r;
  logic                         out_taken_r;
  logic signed [VALUE_BITS-1:0] out_newest_r;

  logic              fire, in_xfer, taken, in_window;
  logic [LIDX_W-1:0] sel;

  assign fire    = in_vld_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_vld_r || fire;
  assign in_xfer = in_if.valid && in_if.ready;

  assign cfg_sel = cfg_idx_t'(cfg_idx);
  assign cfg_ms  = WIN_MS_BITS'(cfg_data[WIN_S_BITS-1:0]) * WIN_MS_BITS'(MS_PER_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r      <= '0;
      smoothing_r <= '0;
      preview_r   <= '0;
      win_lo_r    <= '0;
      win_hi_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_COEF_NOW:       coef_r.q0   <= cfg_data[COEF_BITS-1:0];
        CFG_COEF_PREV:      coef_r.q1   <= cfg_data[COEF_BITS-1:0];
        CFG_COEF_PREV2:     coef_r.q2   <= cfg_data[COEF_BITS-1:0];
        CFG_SMOOTHING:      smoothing_r <= cfg_data[SMOOTH_BITS-1:0];
        CFG_PREVIEW:        preview_r   <= cfg_data[PREVIEW_BITS-1:0];
        CFG_WINDOW_START:   win_lo_r    <= cfg_ms;
        CFG_WINDOW_END:     win_hi_r    <= cfg_ms;
        default: ;          // start setpoint goes straight into slot 0
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_op_r    <= in_if.operation;
      in_meas_r  <= in_if.measured;
      in_offer_r <= in_if.target_offer;
      in_time_r  <= in_if.time_ms;
    end
  end

  // target slot, clamped to the end of the line
  always_comb begin
    if (32'(preview_r) > 32'(LINE_DEPTH - 1)) begin
      sel = LAST_SLOT;
    end else begin
      sel = LIDX_W'(preview_r);
    end
  end

  ipid_pid_calc u_pid_calc (
    .coef_i   (coef_r),
    .target_i (line_r[sel]),
    .meas_i   (in_meas_r),
    .err1_i   (err0_r),
    .err2_i   (err1_r),
    .drive_i  (drive_r),
    .err0_o   (err0_calc),
    .drive_o  (drive_calc)
  );

  ipid_sp_filter u_sp_filter (
    .smoothing_i (smoothing_r),
    .last_i      (filt_r),
    .offer_i     (in_offer_r),
    .filtered_o  (filt_calc)
  );

  assign in_window = ({1'b0, in_time_r} >= win_lo_r) && ({1'b0, in_time_r} <= win_hi_r);
  assign taken     = (in_op_r == OP_SETPOINT) && (in_offer_r != line_r[0]) && in_window;

  assign drive_nxt = (fire && in_op_r == OP_SAMPLE) ? drive_calc : drive_r;

  always_comb begin
    line_nxt = line_r;
    if (fire && taken) begin
      for (int i = 0; i < LINE_DEPTH - 1; i++) begin
        line_nxt[i] = line_r[i + 1];
      end
      line_nxt[LINE_DEPTH - 1] = filt_calc;
    end
    if (cfg_we && cfg_sel == CFG_START_SETPOINT) begin
      line_nxt[0] = cfg_data[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
      err0_r  <= '0;
      err1_r  <= '0;
      filt_r  <= '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_r[i] <= '0;
      end
    end else begin
      drive_r <= drive_nxt;
      line_r  <= line_nxt;
      if (fire && in_op_r == OP_SAMPLE) begin
        err0_r <= err0_calc;
        err1_r <= err0_r;
      end
      if (fire && taken) begin
        filt_r <= filt_calc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive_r  <= drive_nxt;
      out_taken_r  <= taken;
      out_newest_r <= line_nxt[LINE_DEPTH - 1];
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.drive           = out_drive_r;
  assign out_if.setpoint_taken  = out_taken_r;
  assign out_if.newest_setpoint = out_newest_r;

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r <= DRIVE_BITS'(DRIVE_MAX))
    else $error("drive left the 0..5.0 range");

  a_result_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result appeared without an item being processed");

  a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_op_r == OP_SAMPLE |=> err1_r == $past(err0_r))
    else $error("error history did not shift on a sample");

  a_setpoint_keeps_drive: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_op_r == OP_SETPOINT |=> drive_r == $past(drive_r))
    else $error("setpoint item changed the drive");

  a_taken_newest: assert property (@(posedge clk) disable iff (!rst_n)
    fire && taken |=> out_newest_r == filt_r && out_taken_r)
    else $error("newest setpoint does not match the filter state");

endmodule

`default_nettype wire
